// ===== rtl/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// Types and codes shared by the min-heap priority queue and its storage.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 10;

  localparam logic [1:0] MODE_PUSH     = 2'd0;
  localparam logic [1:0] MODE_EXTRACT  = 2'd1;
  localparam logic [1:0] MODE_DECREASE = 2'd2;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_IN_USE = 3'd3,
    ST_ABSENT = 3'd4,
    ST_LARGER = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]                 mode;
    logic signed [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0]        handle;
  } req_t;

  typedef struct packed {
    status_t                    status;
    logic signed [KEY_W-1:0]    min_key;
    logic [HANDLE_W-1:0]        min_handle;
  } rsp_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0]        handle;
  } heap_entry_t;

endpackage

// ===== rtl/mhpq_ram.sv =====
// ----------------------------------------------------------------------------
// mhpq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/min_heap_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// min_heap_priority_queue_unit
// Binary min-heap of signed keys tagged with caller handles, with a handle
// position map for decrease-key.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) carries one operation: push,
//   extract minimum or decrease key. Every request yields exactly one
//   response on the rsp channel (rsp_valid/rsp_stall/rsp) with a status,
//   and on a successful extract the minimum key and its handle.
//   The unit works on one request at a time and stalls req meanwhile.
//   A single key comparator and one read port per RAM are shared by all
//   steps of a sift. Rejected and spare requests, and decrease-key
//   requests with a larger or equal key, are answered without changing
//   the heap. The next request can be taken in the same cycle as the
//   response appears.
//   After reset the unit sweeps the min(HANDLE_COUNT, 1024) entries of the
//   handle map, one entry per cycle, and holds req stalled until done.
//   A finished response waits in the rsp register while rsp_stall is high;
//   the next request is taken meanwhile and its response waits for the
//   register to free up.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_unit
  import mhpq_pkg::*;
#(
  parameter int CAPACITY     = 1024,
  parameter int HANDLE_COUNT = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int PW        = $clog2(CAPACITY);
  localparam int CW        = PW + 1;
  localparam int MAP_DEPTH = (HANDLE_COUNT < (1 << HANDLE_W)) ? HANDLE_COUNT
                                                              : (1 << HANDLE_W);
  localparam int MW        = $clog2(MAP_DEPTH);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_CHECK   = 10'b0000000100,
    S_EX_LAST = 10'b0000001000,
    S_DEC_RD  = 10'b0000010000,
    S_UP      = 10'b0000100000,
    S_DN_L    = 10'b0001000000,
    S_DN_R    = 10'b0010000000,
    S_PLACE   = 10'b0100000000,
    S_FIN     = 10'b1000000000
  } state_t;

  function automatic logic [PW-1:0] parent_of(input logic [PW-1:0] p);
    logic [PW-1:0] t;
    t = p - PW'(1);
    return t >> 1;
  endfunction

  state_t            state, state_next;
  logic [MW-1:0]     clr, clr_next;
  logic [CW-1:0]     count, count_next;
  logic [PW-1:0]     pos, pos_next;
  heap_entry_t       item, item_next;
  heap_entry_t       left, left_next;
  logic              take_left, take_left_next;
  logic              rvalid, rvalid_next;
  req_t              cur, cur_next;
  status_t           status, status_next;
  logic signed [KEY_W-1:0] rkey, rkey_next;
  logic [HANDLE_W-1:0]     rhandle, rhandle_next;
  rsp_t              rsp_next;
  logic              rsp_valid_next;

  // heap storage and handle map ports
  logic              heap_we;
  logic [PW-1:0]     heap_waddr, heap_raddr;
  heap_entry_t       heap_wdata, heap_rd;
  logic              map_we;
  logic [MW-1:0]     map_waddr, map_raddr;
  logic [PW:0]       map_wdata, map_rd;

  // shared comparator
  logic signed [KEY_W-1:0] cmp_a, cmp_b;
  logic                    cmp_lt;

  logic              h_ok;
  logic [PW+1:0]     lc_w, rc_w, nlc_w, cidx_w;
  logic              take_right;
  heap_entry_t       child;
  logic [PW-1:0]     pp;

  assign cmp_lt    = cmp_a < cmp_b;
  assign h_ok      = 32'(cur.handle) < HANDLE_COUNT;
  assign lc_w      = {1'b0, pos, 1'b1};
  assign rc_w      = lc_w + (PW+2)'(1);
  assign req_stall = (state != S_IDLE);

  mhpq_ram #(
    .WIDTH ($bits(heap_entry_t)),
    .DEPTH (CAPACITY)
  ) u_heap (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rd)
  );

  mhpq_ram #(
    .WIDTH (PW + 1),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rd)
  );

  always_comb begin
    state_next     = state;
    clr_next       = clr;
    count_next     = count;
    pos_next       = pos;
    item_next      = item;
    left_next      = left;
    take_left_next = take_left;
    rvalid_next    = rvalid;
    cur_next       = cur;
    status_next    = status;
    rkey_next      = rkey;
    rhandle_next   = rhandle;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid;

    heap_we    = 1'b0;
    heap_waddr = pos;
    heap_wdata = item;
    heap_raddr = '0;
    map_we     = 1'b0;
    map_waddr  = item.handle[MW-1:0];
    map_wdata  = {1'b1, pos};
    map_raddr  = req.handle[MW-1:0];

    cmp_a      = item.key;
    cmp_b      = heap_rd.key;
    take_right = 1'b0;
    child      = heap_rd;
    cidx_w     = rc_w;
    nlc_w      = '0;
    pp         = parent_of(pos);

    // drop the response once it has been transferred
    if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr;
        map_wdata = '0;
        clr_next  = clr + MW'(1);
        if (clr == MW'(MAP_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_valid) begin
          cur_next     = req;
          status_next  = ST_OK;
          rkey_next    = '0;
          rhandle_next = '0;
          state_next   = S_CHECK;
        end
      end

      S_CHECK: begin
        case (cur.mode)
          MODE_PUSH: begin
            if (count >= CW'(CAPACITY)) begin
              status_next = ST_FULL;
              state_next  = S_FIN;
            end else if (!h_ok) begin
              status_next = ST_ABSENT;
              state_next  = S_FIN;
            end else if (map_rd[PW]) begin
              status_next = ST_IN_USE;
              state_next  = S_FIN;
            end else begin
              item_next  = '{key: cur.key, handle: cur.handle};
              pos_next   = count[PW-1:0];
              count_next = count + CW'(1);
              if (count == '0) begin
                state_next = S_PLACE;
              end else begin
                heap_raddr = parent_of(count[PW-1:0]);
                state_next = S_UP;
              end
            end
          end
          MODE_EXTRACT: begin
            if (count == '0) begin
              status_next = ST_EMPTY;
              state_next  = S_FIN;
            end else begin
              rkey_next    = heap_rd.key;
              rhandle_next = heap_rd.handle;
              map_we       = 1'b1;
              map_waddr    = heap_rd.handle[MW-1:0];
              map_wdata    = '0;
              count_next   = count - CW'(1);
              heap_raddr   = PW'(count - CW'(1));
              state_next   = S_EX_LAST;
            end
          end
          MODE_DECREASE: begin
            if (!h_ok || !map_rd[PW] || ({1'b0, map_rd[PW-1:0]} >= count)) begin
              status_next = ST_ABSENT;
              state_next  = S_FIN;
            end else begin
              pos_next   = map_rd[PW-1:0];
              heap_raddr = map_rd[PW-1:0];
              state_next = S_DEC_RD;
            end
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end

      S_EX_LAST: begin
        if (count == '0) begin
          state_next = S_FIN;
        end else begin
          item_next = heap_rd;
          pos_next  = '0;
          if (count > CW'(1)) begin
            heap_raddr = PW'(1);
            state_next = S_DN_L;
          end else begin
            state_next = S_PLACE;
          end
        end
      end

      S_DEC_RD: begin
        cmp_a = heap_rd.key;
        cmp_b = cur.key;
        if (cmp_lt) begin
          status_next = ST_LARGER;
          state_next  = S_FIN;
        end else if (heap_rd.key == cur.key) begin
          state_next = S_FIN;
        end else begin
          item_next = '{key: cur.key, handle: heap_rd.handle};
          if (pos == '0) begin
            state_next = S_PLACE;
          end else begin
            heap_raddr = parent_of(pos);
            state_next = S_UP;
          end
        end
      end

      S_UP: begin
        // heap_rd holds the parent of pos
        if (cmp_lt) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rd;
          map_we     = 1'b1;
          map_waddr  = heap_rd.handle[MW-1:0];
          pos_next   = pp;
          if (pp == '0) begin
            state_next = S_PLACE;
          end else begin
            heap_raddr = parent_of(pp);
          end
        end else begin
          state_next = S_PLACE;
        end
      end

      S_DN_L: begin
        // heap_rd holds the left child
        cmp_a          = heap_rd.key;
        cmp_b          = item.key;
        left_next      = heap_rd;
        take_left_next = cmp_lt;
        if (rc_w < (PW+2)'(count)) begin
          heap_raddr  = rc_w[PW-1:0];
          rvalid_next = 1'b1;
        end else begin
          rvalid_next = 1'b0;
        end
        state_next = S_DN_R;
      end

      S_DN_R: begin
        // heap_rd holds the right child when rvalid
        cmp_a      = heap_rd.key;
        cmp_b      = take_left ? left.key : item.key;
        take_right = rvalid && cmp_lt;
        if (take_right) begin
          child  = heap_rd;
          cidx_w = rc_w;
        end else begin
          child  = left;
          cidx_w = lc_w;
        end
        nlc_w = {1'b0, cidx_w[PW-1:0], 1'b1};
        if (take_right || take_left) begin
          heap_we    = 1'b1;
          heap_wdata = child;
          map_we     = 1'b1;
          map_waddr  = child.handle[MW-1:0];
          pos_next   = cidx_w[PW-1:0];
          if (nlc_w < (PW+2)'(count)) begin
            heap_raddr = nlc_w[PW-1:0];
            state_next = S_DN_L;
          end else begin
            state_next = S_PLACE;
          end
        end else begin
          state_next = S_PLACE;
        end
      end

      S_PLACE: begin
        heap_we    = 1'b1;
        map_we     = 1'b1;
        state_next = S_FIN;
      end

      S_FIN: begin
        // hold until the response register is free
        if (!rsp_valid || !rsp_stall) begin
          rsp_next       = '{status: status, min_key: rkey, min_handle: rhandle};
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
    pos       <= pos_next;
    item      <= item_next;
    left      <= left_next;
    take_left <= take_left_next;
    rvalid    <= rvalid_next;
    cur       <= cur_next;
    status    <= status_next;
    rkey      <= rkey_next;
    rhandle   <= rhandle_next;
    rsp       <= rsp_next;
  end

endmodule
